// ===== hw/rtl/pfx_pkg.sv =====
// shared types and constants for the pfor exception patcher
`timescale 1ns / 1ps
package pfx_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int VALUE_WIDTH = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 1'd1;

    localparam logic [1:0] MODE_64  = 2'd0;
    localparam logic [1:0] MODE_128 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    localparam logic [1:0] MODE_RESET  = MODE_256;
    localparam logic [3:0] SHIFT_RESET = 4'd5;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_PAIR   = 2'd1,
        OP_SINGLE = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_RDATA,
        S_RD0,
        S_WR0,
        S_RD1,
        S_WR1,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_ENTRY,
        SEL_EX0,
        SEL_EX1
    } t_sel;

    typedef struct packed {
        logic latch;
        logic ram_en;
        logic ram_we;
        t_sel sel;
        logic push;
        logic push_read;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/pfx_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
module pfx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pfx_datapath.sv =====
// datapath: config registers, record decode, value store and output register
`timescale 1ns / 1ps
module pfx_datapath import pfx_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  t_opcode                i_in_op,
    input  logic [47:0]            i_in_data,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [VALUE_WIDTH-1:0] o_out_data
);

    logic [1:0]             r_mode;
    logic [3:0]             r_shift;
    logic [IDX_W-1:0]       r_entry_index;
    logic [VALUE_WIDTH-1:0] r_entry_value;
    logic [IDX_W-1:0]       r_idx0;
    logic [IDX_W-1:0]       r_idx1;
    logic [VALUE_WIDTH-1:0] r_inc0;
    logic [VALUE_WIDTH-1:0] r_inc1;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_data;

    logic [15:0]            w0;
    logic [15:0]            w1;
    logic [7:0]             pair_i0;
    logic [7:0]             pair_i1;
    logic [15:0]            pair_x0;
    logic [15:0]            pair_x1;
    logic [7:0]             single_i;
    logic [15:0]            single_x;
    logic [7:0]             n_idx0;
    logic [15:0]            n_x0;

    logic [IDX_W-1:0]       ram_addr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic                   out_free;

    assign w0 = i_in_data[15:0];
    assign w1 = i_in_data[23:8];

    always_comb begin
        case (r_mode)
            MODE_64: begin
                pair_i0  = {2'b0, w0[5:0]};
                pair_x0  = {10'b0, w0[11:6]};
                pair_x1  = {10'b0, w1[9:4]};
                pair_i1  = {2'b0, w1[15:10]};
                single_i = {2'b0, w0[5:0]};
                single_x = {6'b0, w0[15:6]};
            end
            MODE_128: begin
                pair_i0  = {1'b0, w0[6:0]};
                pair_x0  = {11'b0, w0[11:7]};
                pair_x1  = {11'b0, w1[8:4]};
                pair_i1  = {1'b0, w1[15:9]};
                single_i = {1'b0, w0[6:0]};
                single_x = {7'b0, w0[15:7]};
            end
            default: begin
                pair_i0  = w0[7:0];
                pair_x0  = {12'b0, w0[11:8]};
                pair_x1  = {12'b0, w1[7:4]};
                pair_i1  = w1[15:8];
                single_i = w0[7:0];
                single_x = {8'b0, w0[15:8]};
            end
        endcase
        if (i_in_op == OP_SINGLE) begin
            n_idx0 = single_i;
            n_x0   = single_x;
        end else begin
            n_idx0 = pair_i0;
            n_x0   = pair_x0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RESET;
            r_shift <= SHIFT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_MODE:   r_mode  <= i_cfg_wdata[1:0];
                REG_SHIFT_AMOUNT: r_shift <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_entry_index <= i_in_data[24 +: IDX_W];
            r_entry_value <= i_in_data[47:32];
            r_idx0        <= n_idx0[IDX_W-1:0];
            r_idx1        <= pair_i1[IDX_W-1:0];
            r_inc0        <= n_x0 << r_shift;
            r_inc1        <= pair_x1 << r_shift;
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_EX0: begin
                ram_addr  = r_idx0;
                ram_wdata = ram_rdata + r_inc0;
            end
            SEL_EX1: begin
                ram_addr  = r_idx1;
                ram_wdata = ram_rdata + r_inc1;
            end
            default: begin
                ram_addr  = r_entry_index;
                ram_wdata = r_entry_value;
            end
        endcase
    end

    pfx_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (i_cmd.ram_en),
        .i_we    (i_cmd.ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && out_free) begin
            r_out_data <= i_cmd.push_read ? ram_rdata : '0;
        end
    end

    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// ===== hw/rtl/pfx_ctrl.sv =====
// controller state machine sequencing store accesses for each beat
`timescale 1ns / 1ps
module pfx_ctrl import pfx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_opcode i_in_op,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state  r_state;
    t_state  n_state;
    t_opcode r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd.latch) begin
            r_op <= i_in_op;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.latch     = 1'b0;
        o_cmd.ram_en    = 1'b0;
        o_cmd.ram_we    = 1'b0;
        o_cmd.sel       = SEL_ENTRY;
        o_cmd.push      = 1'b0;
        o_cmd.push_read = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    case (i_in_op)
                        OP_WRITE: n_state = S_WRITE;
                        OP_READ:  n_state = S_READ;
                        default:  n_state = S_RD0;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.ram_en = 1'b1;
                o_cmd.ram_we = 1'b1;
                n_state      = S_DONE;
            end
            S_READ: begin
                o_cmd.ram_en = 1'b1;
                n_state      = S_RDATA;
            end
            S_RDATA: begin
                o_cmd.push      = 1'b1;
                o_cmd.push_read = 1'b1;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RD0: begin
                o_cmd.ram_en = 1'b1;
                o_cmd.sel    = SEL_EX0;
                n_state      = S_WR0;
            end
            S_WR0: begin
                o_cmd.ram_en = 1'b1;
                o_cmd.ram_we = 1'b1;
                o_cmd.sel    = SEL_EX0;
                n_state      = (r_op == OP_SINGLE) ? S_DONE : S_RD1;
            end
            S_RD1: begin
                o_cmd.ram_en = 1'b1;
                o_cmd.sel    = SEL_EX1;
                n_state      = S_WR1;
            end
            S_WR1: begin
                o_cmd.ram_en = 1'b1;
                o_cmd.ram_we = 1'b1;
                o_cmd.sel    = SEL_EX1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_cmd.push = 1'b1;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pfor_exception_patcher.sv =====
// top level of the pfor exception patcher
//
// Input beats on s_axis carry one operation: tuser is the opcode (write entry,
// patch pair record, patch single record, read entry), tdata the record bytes,
// entry index and entry value. Each input beat yields exactly one output beat
// on m_axis: the entry contents for a read, zero for every other opcode.
// The register port sets block mode and exception shift; write it only while
// the block is idle.
// One beat is handled at a time against a single-ported 256x16 store with a
// registered read. A write takes one store write, a read one store read, a
// single record one read-modify-write pass and a pair record two such passes
// on the one store port. The output beat turns valid in the same cycle in which the
// next beat can be accepted.
// Reset clears the state machine and the output valid and loads block mode 2
// and shift 5; store contents are undefined until written.
// The output register holds a finished beat while m_axis_tready is low; a new
// input beat is still accepted and worked on, and the block waits at its
// result step until the output register frees up.
`timescale 1ns / 1ps
module pfor_exception_patcher import pfx_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [47:0]            s_axis_tdata,  // record_bytes, entry_index, entry_value
    input  logic [1:0]             s_axis_tuser,  // opcode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [VALUE_WIDTH-1:0] m_axis_tdata   // read_value
);

    t_cmd    cmd;
    t_status status;
    t_opcode in_op;

    assign in_op = t_opcode'(s_axis_tuser);

    pfx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (in_op),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pfx_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_op     (in_op),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
